// ===== rtl/pik_pkg.sv =====
// ============================================================================
// pik_pkg: shared types and widths for the two-link leg solver
// Word widths of the fixed-point data path, cell payload structs and
// configuration register codes.
// ============================================================================
package pik_pkg;

    // Input and configuration field widths
    localparam int X_W     = 18;   // target coordinate
    localparam int L_W     = 16;   // link length register
    localparam int IDX_W   = 2;    // configuration register index

    // Cosine-law path
    localparam int REM_W   = 34;   // divider partial remainder
    localparam int D_W     = 33;   // divisor 2*L1*L2
    localparam int Q_W     = 31;   // cosine magnitude, Q30 with integer bit
    localparam int C_W     = 32;   // signed cosine / sine, Q30
    localparam int V_W     = 61;   // radicand 2^60 - c^2
    localparam int RT_W    = 62;   // root accumulator
    localparam int K_W     = 48;   // scaled operands of the hip offset angle

    // Angle unit
    localparam int CW      = 52;   // vectoring datapath width
    localparam int ANG_W   = 32;   // internal binary angle, 2^32 per turn
    localparam int NORM_N  = 6;    // normalizer stages (shift 32,16,...,1)
    localparam int NORM_TOP = 45;  // normalized magnitude reaches 2^45
    localparam int ITER_N  = 32;   // vectoring iterations
    localparam int ATAN_LAT = 1 + NORM_N + ITER_N;

    // Cell row lengths and total pipeline depth
    localparam int DIV_N   = Q_W;
    localparam int SQRT_N  = Q_W;
    localparam int PIPE_N  = 3 + DIV_N + 2 + SQRT_N + 2 + ATAN_LAT;

    // Configuration register codes
    typedef enum logic [IDX_W-1:0] {
        REG_UPPER_LINK = 2'd0,
        REG_LOWER_LINK = 2'd1
    } cfg_reg_t;

    // Restoring divider cell payload
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [D_W-1:0]   d;
        logic [Q_W-1:0]   q;
    } div_t;

    // Square root cell payload
    typedef struct packed {
        logic [V_W-1:0]  v;
        logic [RT_W-1:0] res;
    } sqr_t;

    // Vectoring cell payload
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     ang;
    } crd_t;

    // Per-request values carried alongside the arithmetic rows
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] z;
        logic [L_W-1:0]        l1;
        logic [L_W-1:0]        l2;
        logic                  down;
        logic                  reach;
        logic                  nneg;
        logic signed [C_W-1:0] c;
        logic signed [K_W-1:0] lc;
    } side_t;

endpackage

// ===== rtl/pik_div_cell.sv =====
// ============================================================================
// pik_div_cell: one quotient bit of the cosine divider
// Compares the partial remainder with the divisor, subtracts on a hit,
// shifts the remainder for the next cell and appends the quotient bit.
// ============================================================================
module pik_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  pik_pkg::div_t d_in,
    output pik_pkg::div_t d_out
);

    pik_pkg::div_t cell_reg;
    pik_pkg::div_t cell_next;
    logic [pik_pkg::REM_W-1:0] dvs;
    logic                      hit;

    assign dvs = {1'b0, d_in.d};
    assign hit = (d_in.rem >= dvs);

    // one restoring step
    always_comb begin
        cell_next = d_in;
        if (hit) begin
            cell_next.rem = (d_in.rem - dvs) << 1;
        end else begin
            cell_next.rem = d_in.rem << 1;
        end
        cell_next.q = {d_in.q[pik_pkg::Q_W-2:0], hit};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

// ===== rtl/pik_sqrt_cell.sv =====
// ============================================================================
// pik_sqrt_cell: one root digit of the knee sine square root
// Digit-by-digit integer square root step at a fixed bit position.
// ============================================================================
module pik_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  pik_pkg::sqr_t s_in,
    output pik_pkg::sqr_t s_out
);

    localparam int RW = pik_pkg::RT_W;
    localparam int VW = pik_pkg::V_W;
    localparam logic [RW-1:0] BITV = RW'(1) << BIT_POS;

    pik_pkg::sqr_t cell_reg;
    pik_pkg::sqr_t cell_next;
    logic [RW-1:0] trial;
    logic          hit;

    assign trial = s_in.res + BITV;
    assign hit   = ({1'b0, s_in.v} >= trial);

    // trial subtract and root update
    always_comb begin
        cell_next = s_in;
        if (hit) begin
            cell_next.v   = s_in.v - trial[VW-1:0];
            cell_next.res = (s_in.res >> 1) + BITV;
        end else begin
            cell_next.res = s_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign s_out = cell_reg;

endmodule

// ===== rtl/pik_cordic_cell.sv =====
// ============================================================================
// pik_cordic_cell: one vectoring micro-rotation
// Rotates toward the x axis by the fixed arctangent of 2^-IDX and
// accumulates the angle.
// ============================================================================
module pik_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  pik_pkg::crd_t c_in,
    output pik_pkg::crd_t c_out
);

    // arctan(2^-i) in 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    pik_pkg::crd_t cell_reg;
    pik_pkg::crd_t cell_next;
    logic signed [pik_pkg::CW-1:0] xs, ys, dx, dy;

    assign xs = c_in.x;
    assign ys = c_in.y;
    assign dx = ys >>> IDX;
    assign dy = xs >>> IDX;

    // rotate by the sign of y
    always_comb begin
        if (!ys[pik_pkg::CW-1]) begin
            cell_next.x   = xs + dx;
            cell_next.y   = ys - dy;
            cell_next.ang = c_in.ang + ATAN_TAB[IDX];
        end else begin
            cell_next.x   = xs - dx;
            cell_next.y   = ys + dy;
            cell_next.ang = c_in.ang - ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign c_out = cell_reg;

endmodule

// ===== rtl/pik_atan2.sv =====
// ============================================================================
// pik_atan2: pipelined four-quadrant arctangent
// Half-turn fold, staged normalization to 2^45 and a row of vectoring
// cells. Result angle in 2^32 units per turn, plus an all-zero flag.
// ============================================================================
module pik_atan2 (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [pik_pkg::CW-1:0] y_in,
    input  logic signed [pik_pkg::CW-1:0] x_in,
    output logic [pik_pkg::ANG_W-1:0]     ang_out,
    output logic                          zero_out
);

    localparam int CW = pik_pkg::CW;
    localparam int NN = pik_pkg::NORM_N;
    localparam int IN = pik_pkg::ITER_N;
    localparam int ZL = pik_pkg::ATAN_LAT;

    pik_pkg::crd_t stg_reg [NN+1];
    logic [CW-1:0] mag_reg [NN+1];
    logic [ZL-1:0] zero_reg;
    pik_pkg::crd_t cor_bus [IN];

    logic signed [CW-1:0] px, py, ay;
    logic                 xneg;

    // fold the left half plane onto the right one
    assign xneg = x_in[CW-1];
    assign px   = xneg ? -x_in : x_in;
    assign py   = xneg ? -y_in : y_in;
    assign ay   = py[CW-1] ? -py : py;

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0].x   <= px;
            stg_reg[0].y   <= py;
            stg_reg[0].ang <= {xneg, {(pik_pkg::ANG_W-1){1'b0}}};
            mag_reg[0]     <= (px > ay) ? px : ay;
            zero_reg       <= {zero_reg[ZL-2:0], (x_in == '0) && (y_in == '0)};
        end
    end

    // normalizer: shift left by 32,16,..,1 while the magnitude stays small
    for (genvar k = 0; k < NN; k++) begin : g_norm
        localparam int SH = 32 >> k;
        localparam logic [CW-1:0] LIM = CW'(1) << (pik_pkg::NORM_TOP + 1 - SH);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (mag_reg[k] < LIM) begin
                    stg_reg[k+1].x <= stg_reg[k].x <<< SH;
                    stg_reg[k+1].y <= stg_reg[k].y <<< SH;
                    mag_reg[k+1]   <= mag_reg[k] << SH;
                end else begin
                    stg_reg[k+1].x <= stg_reg[k].x;
                    stg_reg[k+1].y <= stg_reg[k].y;
                    mag_reg[k+1]   <= mag_reg[k];
                end
                stg_reg[k+1].ang <= stg_reg[k].ang;
            end
        end
    end

    // vectoring row
    for (genvar i = 0; i < IN; i++) begin : g_cell
        if (i == 0) begin : g_first
            pik_cordic_cell #(.IDX(i)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .c_in  (stg_reg[NN]),
                .c_out (cor_bus[i])
            );
        end else begin : g_next
            pik_cordic_cell #(.IDX(i)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .c_in  (cor_bus[i-1]),
                .c_out (cor_bus[i])
            );
        end
    end

    assign ang_out  = cor_bus[IN-1].ang;
    assign zero_out = zero_reg[ZL-1];

endmodule

// ===== rtl/planar_two_link_inverse_kinematics_top.sv =====
// ============================================================================
// planar_two_link_inverse_kinematics_top: two-link leg inverse kinematics
// Cosine-law solution of hip and knee angles for a target point, as a
// fixed-latency pipeline of divider, square root and arctangent cell rows.
// ============================================================================
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  s_      | s_valid / s_ready  | s_target_x, s_target_z, s_elbow_down
//  m_      | m_valid / m_ready  | m_hip_angle, m_knee_angle, m_reachable
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  One request per cycle unless the pipeline stops; it holds rows of
//  31 divider cells, 31 root cells and 39 arctangent stages.
//  The pipeline moves as a whole; it stops only while its last stage holds a
//  result and the output register is full and not taken.
//  Reset (aresetn low, synchronous) empties the pipeline and loads both
//  link lengths with 16384.
// ============================================================================
module planar_two_link_inverse_kinematics_top #(
    parameter int LENGTH_BITS = 16,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [pik_pkg::X_W-1:0] s_target_x,
    input  logic signed [pik_pkg::X_W-1:0] s_target_z,
    input  logic                          s_elbow_down,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ANGLE_BITS-1:0]  m_hip_angle,
    output logic signed [ANGLE_BITS-1:0]  m_knee_angle,
    output logic                          m_reachable,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pik_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pik_pkg::L_W-1:0]       cfg_data
);

    localparam int L_W   = pik_pkg::L_W;
    localparam int K_W   = pik_pkg::K_W;
    localparam int C_W   = pik_pkg::C_W;
    localparam int CW    = pik_pkg::CW;
    localparam int Q_W   = pik_pkg::Q_W;
    localparam int PN    = pik_pkg::PIPE_N;
    localparam int DN    = pik_pkg::DIV_N;
    localparam int SN    = pik_pkg::SQRT_N;
    localparam int AL    = pik_pkg::ATAN_LAT;
    localparam logic [L_W-1:0] LEN_MASK =
        (LENGTH_BITS >= 16) ? 16'hFFFF : L_W'((32'd1 << LENGTH_BITS) - 32'd1);
    localparam logic [31:0] HALF_LSB = 32'd1 << (31 - ANGLE_BITS);

    // ------------------------------------------------------------------
    // configuration registers
    logic [L_W-1:0] upper_len_reg, lower_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= 16'd16384;
            lower_len_reg <= 16'd16384;
        end else if (cfg_valid) begin
            case (pik_pkg::cfg_reg_t'(cfg_index))
                pik_pkg::REG_UPPER_LINK: upper_len_reg <= cfg_data;
                pik_pkg::REG_LOWER_LINK: lower_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: whole-pipeline enable
    logic [PN-1:0] vld_reg;
    logic          m_valid_reg;
    logic          en;

    assign en      = !vld_reg[PN-1] || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PN-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: squares and link products
    logic [L_W-1:0]       l1, l2, mn;
    logic [L_W:0]         mx;
    logic signed [35:0]   xx, zz;
    logic [31:0]          l1l2;
    pik_pkg::side_t       in_side;

    assign l1   = upper_len_reg & LEN_MASK;
    assign l2   = lower_len_reg & LEN_MASK;
    assign mx   = {1'b0, l1} + {1'b0, l2};
    assign mn   = (l1 >= l2) ? (l1 - l2) : (l2 - l1);
    assign xx   = s_target_x * s_target_x;
    assign zz   = s_target_z * s_target_z;
    assign l1l2 = l1 * l2;

    always_comb begin
        in_side       = '0;
        in_side.x     = s_target_x;
        in_side.z     = s_target_z;
        in_side.l1    = l1;
        in_side.l2    = l2;
        in_side.down  = s_elbow_down;
    end

    logic [34:0]    s1_x2_reg, s1_z2_reg;
    logic [31:0]    s1_l1sq_reg, s1_l2sq_reg, s1_mn2_reg;
    logic [33:0]    s1_mx2_reg;
    logic [32:0]    s1_d_reg;
    logic           s1_lz_reg;
    pik_pkg::side_t s1_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x2_reg   <= xx[34:0];
            s1_z2_reg   <= zz[34:0];
            s1_l1sq_reg <= l1 * l1;
            s1_l2sq_reg <= l2 * l2;
            s1_mx2_reg  <= mx * mx;
            s1_mn2_reg  <= mn * mn;
            s1_d_reg    <= {l1l2, 1'b0};
            s1_lz_reg   <= (l1 == '0) || (l2 == '0);
            s1_side_reg <= in_side;
        end
    end

    // stage 2: squared distance and sum of squared lengths
    logic [35:0]    s2_r2_reg;
    logic [32:0]    s2_sumsq_reg;
    logic [31:0]    s2_mn2_reg;
    logic [33:0]    s2_mx2_reg;
    logic [32:0]    s2_d_reg;
    logic           s2_lz_reg;
    pik_pkg::side_t s2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_r2_reg    <= {1'b0, s1_x2_reg} + {1'b0, s1_z2_reg};
            s2_sumsq_reg <= {1'b0, s1_l1sq_reg} + {1'b0, s1_l2sq_reg};
            s2_mn2_reg   <= s1_mn2_reg;
            s2_mx2_reg   <= s1_mx2_reg;
            s2_d_reg     <= s1_d_reg;
            s2_lz_reg    <= s1_lz_reg;
            s2_side_reg  <= s1_side_reg;
        end
    end

    // stage 3: numerator magnitude and reach test
    logic [35:0]    sumsq_w, absn;
    logic           nneg;
    pik_pkg::side_t s3_side_next;
    pik_pkg::div_t  s3_div_reg;
    pik_pkg::side_t s3_side_reg;

    assign sumsq_w = {3'b0, s2_sumsq_reg};
    assign nneg    = (s2_r2_reg >= sumsq_w);
    assign absn    = nneg ? (s2_r2_reg - sumsq_w) : (sumsq_w - s2_r2_reg);

    always_comb begin
        s3_side_next       = s2_side_reg;
        s3_side_next.nneg  = nneg;
        s3_side_next.reach = !s2_lz_reg && (s2_r2_reg <= {2'b0, s2_mx2_reg})
                             && (s2_r2_reg >= {4'b0, s2_mn2_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_div_reg.rem <= absn[pik_pkg::REM_W-1:0];
            s3_div_reg.d   <= s2_d_reg;
            s3_div_reg.q   <= '0;
            s3_side_reg    <= s3_side_next;
        end
    end

    // ------------------------------------------------------------------
    // divider row: cosine magnitude in Q30
    pik_pkg::div_t  div_bus [DN];
    pik_pkg::side_t div_side_reg [DN];

    for (genvar i = 0; i < DN; i++) begin : g_div
        if (i == 0) begin : g_first
            pik_div_cell u_cell (
                .aclk (aclk), .en (en), .d_in (s3_div_reg), .d_out (div_bus[i])
            );
        end else begin : g_next
            pik_div_cell u_cell (
                .aclk (aclk), .en (en), .d_in (div_bus[i-1]), .d_out (div_bus[i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_side_reg[0] <= s3_side_reg;
            for (int i = 1; i < DN; i++) begin
                div_side_reg[i] <= div_side_reg[i-1];
            end
        end
    end

    // stage 4: signed cosine, its square, L2 times magnitude
    logic [Q_W-1:0]  q;
    logic [61:0]     qsq;
    logic [46:0]     lq;
    pik_pkg::side_t  s4_side_next;
    pik_pkg::side_t  s4_side_reg;
    logic [60:0]     s4_csq_reg;
    logic [46:0]     s4_lq_reg;

    assign q   = div_bus[DN-1].q;
    assign qsq = q * q;
    assign lq  = div_side_reg[DN-1].l2 * q;

    always_comb begin
        s4_side_next   = div_side_reg[DN-1];
        s4_side_next.c = div_side_reg[DN-1].nneg ? $signed({1'b0, q})
                                                 : -$signed({1'b0, q});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_side_reg <= s4_side_next;
            s4_csq_reg  <= qsq[60:0];
            s4_lq_reg   <= lq;
        end
    end

    // stage 5: radicand and signed L2*c
    pik_pkg::side_t s5_side_next;
    pik_pkg::side_t s5_side_reg;
    pik_pkg::sqr_t  s5_sqr_reg;

    always_comb begin
        s5_side_next    = s4_side_reg;
        s5_side_next.lc = s4_side_reg.nneg ? $signed({1'b0, s4_lq_reg})
                                           : -$signed({1'b0, s4_lq_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_side_reg    <= s5_side_next;
            s5_sqr_reg.v   <= {1'b1, 60'd0} - s4_csq_reg;
            s5_sqr_reg.res <= '0;
        end
    end

    // ------------------------------------------------------------------
    // square root row: knee sine magnitude in Q30
    pik_pkg::sqr_t  sqr_bus [SN];
    pik_pkg::side_t sqr_side_reg [SN];

    for (genvar i = 0; i < SN; i++) begin : g_sqrt
        if (i == 0) begin : g_first
            pik_sqrt_cell #(.BIT_POS(2 * (SN - 1 - i))) u_cell (
                .aclk (aclk), .en (en), .s_in (s5_sqr_reg), .s_out (sqr_bus[i])
            );
        end else begin : g_next
            pik_sqrt_cell #(.BIT_POS(2 * (SN - 1 - i))) u_cell (
                .aclk (aclk), .en (en), .s_in (sqr_bus[i-1]), .s_out (sqr_bus[i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqr_side_reg[0] <= s5_side_reg;
            for (int i = 1; i < SN; i++) begin
                sqr_side_reg[i] <= sqr_side_reg[i-1];
            end
        end
    end

    // stage 6: branch sine, L2*|s|, hip offset x operand
    logic [Q_W-1:0]        root;
    pik_pkg::side_t        s6_side_reg;
    logic signed [C_W-1:0] s6_sv_reg;
    logic [46:0]           s6_l2r_reg;
    logic signed [K_W-1:0] s6_kx_reg;

    assign root = sqr_bus[SN-1].res[Q_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_side_reg <= sqr_side_reg[SN-1];
            s6_sv_reg   <= sqr_side_reg[SN-1].down ? $signed({1'b0, root})
                                                   : -$signed({1'b0, root});
            s6_l2r_reg  <= sqr_side_reg[SN-1].l2 * root;
            s6_kx_reg   <= $signed({2'b00, sqr_side_reg[SN-1].l1, 30'd0})
                           + sqr_side_reg[SN-1].lc;
        end
    end

    // stage 7: hip offset y operand
    pik_pkg::side_t        s7_side_reg;
    logic signed [C_W-1:0] s7_sv_reg;
    logic signed [K_W-1:0] s7_kx_reg, s7_ky_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_side_reg <= s6_side_reg;
            s7_sv_reg   <= s6_sv_reg;
            s7_kx_reg   <= s6_kx_reg;
            s7_ky_reg   <= s6_side_reg.down ? $signed({1'b0, s6_l2r_reg})
                                            : -$signed({1'b0, s6_l2r_reg});
        end
    end

    // ------------------------------------------------------------------
    // three arctangent units in parallel
    logic signed [CW-1:0]          knee_y, knee_x, phi_y, phi_x, off_y, off_x;
    logic [pik_pkg::ANG_W-1:0]     knee_ang, phi_ang, off_ang;
    logic                          knee_zero, phi_zero, off_zero;

    assign knee_y = {{(CW-C_W){s7_sv_reg[C_W-1]}}, s7_sv_reg};
    assign knee_x = {{(CW-C_W){s7_side_reg.c[C_W-1]}}, s7_side_reg.c};
    assign phi_y  = {{(CW-pik_pkg::X_W){s7_side_reg.z[pik_pkg::X_W-1]}}, s7_side_reg.z};
    assign phi_x  = {{(CW-pik_pkg::X_W){s7_side_reg.x[pik_pkg::X_W-1]}}, s7_side_reg.x};
    assign off_y  = {{(CW-K_W){s7_ky_reg[K_W-1]}}, s7_ky_reg};
    assign off_x  = {{(CW-K_W){s7_kx_reg[K_W-1]}}, s7_kx_reg};

    pik_atan2 u_knee (
        .aclk (aclk), .en (en), .y_in (knee_y), .x_in (knee_x),
        .ang_out (knee_ang), .zero_out (knee_zero)
    );

    pik_atan2 u_phi (
        .aclk (aclk), .en (en), .y_in (phi_y), .x_in (phi_x),
        .ang_out (phi_ang), .zero_out (phi_zero)
    );

    pik_atan2 u_off (
        .aclk (aclk), .en (en), .y_in (off_y), .x_in (off_x),
        .ang_out (off_ang), .zero_out (off_zero)
    );

    // reach flag travels beside the arctangent units
    logic [AL-1:0] reach_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            reach_reg <= {reach_reg[AL-2:0], s7_side_reg.reach};
        end
    end

    // ------------------------------------------------------------------
    // output register: hip = phi - offset, round to ANGLE_BITS
    logic [31:0] knee_a, phi_a, off_a, hip_a, hip_rnd, knee_rnd;
    logic        reach_out;
    logic signed [ANGLE_BITS-1:0] m_hip_reg, m_knee_reg;
    logic        m_reach_reg;

    assign knee_a    = knee_zero ? 32'd0 : knee_ang;
    assign phi_a     = phi_zero ? 32'd0 : phi_ang;
    assign off_a     = off_zero ? 32'd0 : off_ang;
    assign hip_a     = phi_a - off_a;
    assign hip_rnd   = hip_a + HALF_LSB;
    assign knee_rnd  = knee_a + HALF_LSB;
    assign reach_out = reach_reg[AL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && vld_reg[PN-1]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[PN-1]) begin
            m_hip_reg   <= reach_out ? hip_rnd[31 -: ANGLE_BITS] : '0;
            m_knee_reg  <= reach_out ? knee_rnd[31 -: ANGLE_BITS] : '0;
            m_reach_reg <= reach_out;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hip_angle  = m_hip_reg;
    assign m_knee_angle = m_knee_reg;
    assign m_reachable  = m_reach_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: request/result testbench for the two-link leg solver
// Drives target points through the request channel under random idling and
// result back-pressure, works out hip/knee angles with a fixed-point cosine-
// law and vectoring-arctangent predictor, and checks every result in order.
// Link lengths are reprogrammed between phases, extremes included.
// ============================================================================
module tb_top;

    localparam int  X_W        = pik_pkg::X_W;
    localparam int  L_W        = pik_pkg::L_W;
    localparam int  IDX_W      = pik_pkg::IDX_W;
    localparam int  LATENCY    = 109;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;   // index past the list
    localparam logic [IDX_W-1:0] REG_FREE  = 2'd2;   // unused index

    localparam logic [31:0] ATAN_LUT [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] z;
        logic                  down;
    } target_t;

    typedef struct {
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic               reach;
    } joints_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [X_W-1:0] s_target_x = '0;
    logic signed [X_W-1:0] s_target_z = '0;
    logic                  s_elbow_down = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [15:0]    m_hip_angle;
    logic signed [15:0]    m_knee_angle;
    logic                  m_reachable;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [L_W-1:0]        cfg_data = '0;

    target_t     target_q[$];
    joints_t     joints_q[$];
    logic [15:0] upper_len = 16'd16384;
    logic [15:0] lower_len = 16'd16384;
    logic        req_taken = 1'b0;
    logic        no_idle = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;

    planar_two_link_inverse_kinematics_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_target_x(s_target_x), .s_target_z(s_target_z),
        .s_elbow_down(s_elbow_down),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hip_angle(m_hip_angle), .m_knee_angle(m_knee_angle),
        .m_reachable(m_reachable),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock and run-length guard
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // atan2 in 2^32 units per turn: half-plane fold, normalize, 32 rotations
    function automatic logic [31:0] atan2_turns(longint y, longint x);
        logic [31:0] ang;
        longint      ay, m, dx, dy;
        ang = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        while (m < (64'sd1 <<< 45)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                ang = ang + ATAN_LUT[i];
            end else begin
                x = x - dx;
                y = y + dy;
                ang = ang - ATAN_LUT[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [15:0] to_angle16(logic [31:0] a);
        logic [32:0] v;
        v = {1'b0, a} + 33'h8000;
        return v[31:16];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // cosine-law solution for one target under the current link lengths
    function automatic joints_t solve_joints(target_t t);
        joints_t         j;
        longint          l1, l2, x, z, r2, mx, mn, n, d, c, s;
        longint unsigned q;
        logic [31:0]     phi, k;
        j = '{hip: '0, knee: '0, reach: 1'b0};
        l1 = longint'(upper_len);
        l2 = longint'(lower_len);
        x = longint'(t.x);
        z = longint'(t.z);
        if (l1 == 0 || l2 == 0) return j;
        r2 = x * x + z * z;
        mx = l1 + l2;
        mn = (l1 > l2) ? l1 - l2 : l2 - l1;
        if (r2 > mx * mx || r2 < mn * mn) return j;
        n = r2 - l1 * l1 - l2 * l2;
        d = 2 * l1 * l2;
        if (n > d) n = d;
        if (n < -d) n = -d;
        q = (unsigned'(n < 0 ? -n : n) << 30) / unsigned'(d);
        c = (n < 0) ? -longint'(q) : longint'(q);
        s = longint'(root_floor((64'd1 << 60) - unsigned'(c * c)));
        if (!t.down) s = -s;
        phi = atan2_turns(z, x);
        k = atan2_turns(l2 * s, (l1 <<< 30) + l2 * c);
        j.hip = to_angle16(phi - k);
        j.knee = to_angle16(atan2_turns(s, c));
        j.reach = 1'b1;
        return j;
    endfunction

    // request driver: hold until taken, else next target or a random idle
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !req_taken)) begin
            if (target_q.size() > 0 && (no_idle || $urandom_range(99) >= 18)) begin
                s_target_x <= target_q[0].x;
                s_target_z <= target_q[0].z;
                s_elbow_down <= target_q[0].down;
                void'(target_q.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && (no_idle || $urandom_range(99) >= 18);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        joints_t exp_j;
        target_t t;
        req_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == pik_pkg::REG_UPPER_LINK) upper_len = cfg_data;
                else if (cfg_index == pik_pkg::REG_LOWER_LINK) lower_len = cfg_data;
            end
            if (s_valid && s_ready) begin
                req_taken = 1'b1;
                t = '{x: s_target_x, z: s_target_z, down: s_elbow_down};
                joints_q.push_back(solve_joints(t));
            end
            if (m_valid && m_ready) begin
                if (joints_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result hip=%0d knee=%0d reach=%0b",
                                 m_hip_angle, m_knee_angle, m_reachable);
                end else begin
                    exp_j = joints_q.pop_front();
                    if (m_hip_angle !== exp_j.hip || m_knee_angle !== exp_j.knee ||
                        m_reachable !== exp_j.reach) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp hip=%0d knee=%0d reach=%0b, got %0d %0d %0b",
                                     exp_j.hip, exp_j.knee, exp_j.reach,
                                     m_hip_angle, m_knee_angle, m_reachable);
                    end
                end
            end
        end
    end

    task automatic write_link(logic [IDX_W-1:0] idx, logic [L_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_target(int x, int z, logic down);
        target_q.push_back('{x: X_W'(x), z: X_W'(z), down: down});
    endtask

    // mostly points within the reach box, the rest raw random bits
    task automatic add_random_targets(int count);
        int reach_box;
        reach_box = int'(upper_len) + int'(lower_len);
        if (reach_box > 131071) reach_box = 131071;
        if (reach_box < 1) reach_box = 1;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70)
                add_target(int'($urandom_range(2 * reach_box)) - reach_box,
                           int'($urandom_range(2 * reach_box)) - reach_box,
                           1'($urandom_range(1)));
            else
                add_target($urandom, $urandom, 1'($urandom_range(1)));
        end
    endtask

    task automatic drain();
        wait (target_q.size() == 0 && !s_valid && joints_q.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, reach bounds, target at hip, branches
        add_target(0, 0, 1'b1);
        add_target(32768, 0, 1'b1);
        add_target(32768, 0, 1'b0);
        add_target(-32768, 0, 1'b1);
        add_target(0, -32768, 1'b0);
        add_target(32769, 0, 1'b1);
        add_target(131071, 131071, 1'b1);
        add_target(-131072, -131072, 1'b0);
        add_target(-131072, 0, 1'b1);
        add_target(0, 131071, 1'b0);
        add_target(-20000, 1, 1'b1);
        add_target(-20000, -1, 1'b0);
        add_target(16384, 16384, 1'b1);
        add_target(-16384, 16384, 1'b0);
        add_target(23170, -23170, 1'b1);
        add_target(1, 0, 1'b1);
        add_random_targets(200);
        drain();

        // no idling on either side for this phase
        no_idle <= 1'b1;
        write_link(pik_pkg::REG_UPPER_LINK, 16'd65535);
        write_link(pik_pkg::REG_LOWER_LINK, 16'd65535);
        add_target(131070, 0, 1'b1);
        add_target(-131072, 0, 1'b0);
        add_random_targets(220);
        drain();
        no_idle <= 1'b0;

        // one zero link: nothing is reachable
        write_link(pik_pkg::REG_UPPER_LINK, 16'd0);
        add_random_targets(40);
        drain();
        write_link(pik_pkg::REG_UPPER_LINK, 16'd1000);
        write_link(pik_pkg::REG_LOWER_LINK, 16'd0);
        add_random_targets(40);
        drain();

        // extreme ratio, then tiny links
        write_link(pik_pkg::REG_LOWER_LINK, 16'd1);
        write_link(pik_pkg::REG_UPPER_LINK, 16'd65535);
        add_target(65534, 0, 1'b1);
        add_target(0, 65536, 1'b0);
        add_random_targets(200);
        drain();
        write_link(pik_pkg::REG_UPPER_LINK, 16'd1);
        write_link(pik_pkg::REG_LOWER_LINK, 16'd1);
        add_target(2, 0, 1'b1);
        add_target(1, 1, 1'b0);
        add_target(0, 0, 1'b1);
        add_random_targets(100);
        drain();

        // writes past the register list leave the lengths alone
        write_link(pik_pkg::REG_UPPER_LINK, 16'd300);
        write_link(pik_pkg::REG_LOWER_LINK, 16'd700);
        write_link(REG_SPARE, 16'd5);
        write_link(REG_FREE, 16'd9);
        add_random_targets(150);
        drain();

        // random lengths
        for (int p = 0; p < 3; p++) begin
            write_link(pik_pkg::REG_UPPER_LINK, 16'($urandom));
            write_link(pik_pkg::REG_LOWER_LINK, 16'($urandom));
            add_random_targets(130);
            drain();
        end

        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && joints_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pik_pkg.sv
rtl/pik_div_cell.sv
rtl/pik_sqrt_cell.sv
rtl/pik_cordic_cell.sv
rtl/pik_atan2.sv
rtl/planar_two_link_inverse_kinematics_top.sv
test/tb_top.sv
